>>> sv/swcrc_pkg.sv
// Shared types, constants and CRC-8 helpers for the single-wire request master.
// No dependencies; imported by swcrc_core and single_wire_crc8_request_master.
package swcrc_pkg;

    localparam int REQUEST_BITS = 16;
    localparam int REPLY_BITS   = 32;
    localparam int REPLY_DATA_BITS = 24;

    localparam logic [7:0] CRC_POLY        = 8'h07;
    localparam logic [7:0] REQUEST_MARK    = 8'h80;
    localparam logic [7:0] START_LOW_TICKS = 8'd2;

    localparam logic [7:0] RESET_HIGH_TICKS_DEFAULT = 8'd60;
    localparam logic [2:0] MAX_ATTEMPTS_DEFAULT     = 3'd3;
    localparam logic [6:0] VALUE_LIMIT_DEFAULT      = 7'd127;
    localparam logic [7:0] CRC_SEED_DEFAULT         = 8'hAC;

    typedef enum logic [1:0] {
        CFG_RESET_HIGH_TICKS = 2'd0,
        CFG_MAX_ATTEMPTS     = 2'd1,
        CFG_VALUE_LIMIT      = 2'd2,
        CFG_CRC_SEED         = 2'd3
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_RESET_HIGH = 7'b0000010,
        PH_START_LOW  = 7'b0000100,
        PH_SEND       = 7'b0001000,
        PH_RELEASE    = 7'b0010000,
        PH_TURN       = 7'b0100000,
        PH_SAMPLE     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [2:0]  attempts_used;
        logic [31:0] reply_word;
        logic        success;
        logic        done_res;
        logic        busy_res;
        logic        line_output_enable;
        logic        line_drive;
    } t_result;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic data_bit);
        logic fb;
        fb = crc[7] ^ data_bit;
        return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] seed, input logic [7:0] data);
        logic [7:0] crc;
        crc = seed;
        for (int i = 7; i >= 0; i--) begin
            crc = crc8_step(crc, data[i]);
        end
        return crc;
    endfunction

endpackage

>>> sv/swcrc_core.sv
// Session sequencer: configuration registers, phase machine, shift registers
// and running reply CRC. Depends on swcrc_pkg.
module swcrc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [7:0]        i_request_value,
    input  logic              i_line_level,
    output swcrc_pkg::t_result o_result
);
    import swcrc_pkg::*;

    logic [7:0]  r_reset_high_ticks;
    logic [2:0]  r_max_attempts;
    logic [6:0]  r_value_limit;
    logic [7:0]  r_crc_seed;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tick, n_tick;
    logic [15:0] r_send, n_send;
    logic [31:0] r_reply, n_reply;
    logic [2:0]  r_att, n_att;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_crc, n_crc;

    logic [7:0]  tick_inc;
    logic [7:0]  lim;
    logic [7:0]  clamped;
    logic        drive, oe, done, ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_high_ticks <= RESET_HIGH_TICKS_DEFAULT;
            r_max_attempts     <= MAX_ATTEMPTS_DEFAULT;
            r_value_limit      <= VALUE_LIMIT_DEFAULT;
            r_crc_seed         <= CRC_SEED_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RESET_HIGH_TICKS: r_reset_high_ticks <= i_cfg_data;
                CFG_MAX_ATTEMPTS:     r_max_attempts     <= i_cfg_data[2:0];
                CFG_VALUE_LIMIT:      r_value_limit      <= i_cfg_data[6:0];
                CFG_CRC_SEED:         r_crc_seed         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_send  = r_send;
        n_reply = r_reply;
        n_att   = r_att;
        n_held  = r_held;
        n_crc   = r_crc;
        drive   = 1'b1;
        oe      = 1'b1;
        done    = 1'b0;
        ok      = 1'b0;
        tick_inc = r_tick + 8'd1;
        lim      = (r_reset_high_ticks == 8'd0) ? 8'd1 : r_reset_high_ticks;
        clamped  = (i_request_value > {1'b0, r_value_limit}) ? {1'b0, r_value_limit}
                                                             : i_request_value;
        if (i_mode) begin
            n_held  = clamped | REQUEST_MARK;
            n_send  = {n_held, crc8_byte(r_crc_seed, n_held)};
            n_att   = 3'd1;
            n_phase = PH_RESET_HIGH;
            n_tick  = 8'd0;
            n_reply = 32'd0;
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_RESET_HIGH: begin
                    n_tick = tick_inc;
                    if (tick_inc >= lim) begin
                        n_phase = PH_START_LOW;
                        n_tick  = 8'd0;
                    end
                end
                PH_START_LOW: begin
                    drive  = 1'b0;
                    n_tick = tick_inc;
                    if (tick_inc >= START_LOW_TICKS) begin
                        n_phase = PH_SEND;
                        n_tick  = 8'd0;
                    end
                end
                PH_SEND: begin
                    drive  = r_send[REQUEST_BITS-1];
                    n_send = {r_send[REQUEST_BITS-2:0], r_send[REQUEST_BITS-1]};
                    n_tick = tick_inc;
                    if (tick_inc >= 8'(REQUEST_BITS)) begin
                        n_phase = PH_RELEASE;
                        n_tick  = 8'd0;
                    end
                end
                PH_RELEASE: begin
                    drive   = r_send[0];
                    n_phase = PH_TURN;
                end
                PH_TURN: begin
                    drive   = 1'b0;
                    oe      = 1'b0;
                    n_phase = PH_SAMPLE;
                    n_tick  = 8'd0;
                    n_crc   = r_crc_seed;
                end
                PH_SAMPLE: begin
                    drive   = 1'b0;
                    oe      = 1'b0;
                    n_reply = {r_reply[REPLY_BITS-2:0], i_line_level};
                    n_tick  = tick_inc;
                    // top 24 reply bits fold into the CRC as they arrive
                    if (tick_inc <= 8'(REPLY_DATA_BITS)) begin
                        n_crc = crc8_step(r_crc, i_line_level);
                    end
                    if (tick_inc >= 8'(REPLY_BITS)) begin
                        if (r_crc == n_reply[7:0]) begin
                            done    = 1'b1;
                            ok      = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (r_att < r_max_attempts) begin
                            n_att   = r_att + 3'd1;
                            n_phase = PH_RESET_HIGH;
                            n_tick  = 8'd0;
                        end else begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign o_result = '{attempts_used:      n_att,
                        reply_word:         n_reply,
                        success:            ok,
                        done_res:           done,
                        busy_res:           (n_phase != PH_IDLE),
                        line_output_enable: oe,
                        line_drive:         drive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_send  <= 16'd0;
            r_reply <= 32'd0;
            r_att   <= 3'd0;
            r_held  <= 8'd0;
            r_crc   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_send  <= n_send;
            // a new session starts with a cleared reply
            r_reply <= (n_phase == PH_RESET_HIGH && n_tick == 8'd0) ? 32'd0 : n_reply;
            r_att   <= n_att;
            r_held  <= n_held;
            r_crc   <= n_crc;
        end
    end

endmodule

>>> sv/single_wire_crc8_request_master.sv
// Top level of the single-wire CRC-8 request master: stream ports, config port
// and result register. Depends on swcrc_pkg and swcrc_core.
//
// Usage: each request on the slave stream is either a timer tick (tuser = 0)
// or a start (tuser = 1, tdata[7:0] = value to send). A start clamps the value
// to value_limit, sets bit 7 and appends its CRC-8; the following ticks walk
// the session: line high for reset_high_ticks, low for two ticks, 16 request
// bits MSB first, one release tick, one turnaround tick, then 32 reply bits
// sampled from line_level. A failed reply CRC starts a new attempt, up to max_attempts in all.
// Every request yields exactly one result request on the master stream
// carrying line drive/enable, busy, done, success, reply word and attempts.
// o_m_axis_tvalid rises in the cycle after input acceptance. While the receiver
// keeps up, one request is taken per clock; the result register is refilled in the same
// cycle it is drained. When the receiver stalls, o_s_axis_tready drops until the
// held result is taken. Reset (synchronous, active low) loads the register
// defaults, returns the session to idle and empties the result register.
// Config writes on i_cfg_we take effect at the next edge.
module single_wire_crc8_request_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] request_value, [8] line_level, rest zero
    input  logic [0:0]  i_s_axis_tuser,  // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // [0] line_drive, [1] line_output_enable,
                                         // [2] busy_res, [3] done_res, [4] success,
                                         // [36:5] reply_word, [39:37] attempts_used
);
    import swcrc_pkg::*;

    logic    accept;
    t_result core_result;
    t_result r_out;
    logic    r_out_valid;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    swcrc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_mode          (i_s_axis_tuser[0]),
        .i_request_value (i_s_axis_tdata[7:0]),
        .i_line_level    (i_s_axis_tdata[8]),
        .o_result        (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule
